// ===== rtl/core/tolerance_compare_error_indexer_macros.svh =====
// ----------------------------------------------------------------------------
// Tolerance compare error indexer: assertion macros
// Clocked assertions on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TOLERANCE_COMPARE_ERROR_INDEXER_MACROS_SVH
`define TOLERANCE_COMPARE_ERROR_INDEXER_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define TCI_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true out of reset.
`define TCI_ASSERT_NEVER(name, cond, msg) \
    `TCI_ASSERT(name, !(cond), msg)

`endif

// ===== rtl/core/tci_pkg.sv =====
// ----------------------------------------------------------------------------
// tci_pkg
// Types, register codes and defaults for the tolerance compare error indexer.
// ----------------------------------------------------------------------------
package tci_pkg;

    localparam int NUM_EXTENTS  = 4;
    localparam int DEF_MAX_DIMS = 4;
    localparam int VALUE_W      = 32;
    localparam int TOL_W        = 32;
    localparam int COORD_W      = 16;
    localparam int COUNT_W      = 32;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_ABS_TOL  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REL_TOL  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_0 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_1 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_2 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_3 = 3'd5;

    typedef logic [NUM_EXTENTS-1:0][COORD_W-1:0] coord_vec_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] test_value;
        logic signed [VALUE_W-1:0] ref_value;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic                      is_error;
        logic [COORD_W-1:0]        coord_0;
        logic [COORD_W-1:0]        coord_1;
        logic [COORD_W-1:0]        coord_2;
        logic [COORD_W-1:0]        coord_3;
        logic signed [VALUE_W-1:0] echo_test;
        logic signed [VALUE_W-1:0] echo_ref;
        logic [COUNT_W-1:0]        error_total;
        logic                      end_of_array;
    } out_item_t;

    typedef struct packed {
        logic step;
        logic clear;
    } odo_cmd_t;

endpackage

// ===== rtl/core/tci_stream_if.sv =====
// ----------------------------------------------------------------------------
// tci_stream_if
// Valid/ready channel carrying one item of a chosen payload type.
// ----------------------------------------------------------------------------
interface tci_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tci_odometer.sv =====
// ----------------------------------------------------------------------------
// tci_odometer
// Row-major element coordinate counter over the configured extents.
// ----------------------------------------------------------------------------
module tci_odometer
    import tci_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  odo_cmd_t   cmd,
    input  coord_vec_t extent,
    output coord_vec_t coord
);

    localparam int ACTIVE_DIMS = (MAX_DIMS < NUM_EXTENTS) ? MAX_DIMS : NUM_EXTENTS;

    coord_vec_t coord_reg;
    coord_vec_t coord_next;

    always_comb
    begin
        logic               carry;
        logic               wrap;
        logic [COORD_W:0]   inc;
        carry      = cmd.step;
        coord_next = coord_reg;
        for (int i = 0; i < NUM_EXTENTS; i++)
        begin
            inc  = {1'b0, coord_reg[i]} + {{COORD_W{1'b0}}, 1'b1};
            // a coordinate at or past its extent (or a zero extent) wraps
            wrap = (inc >= {1'b0, extent[i]});
            if (i < ACTIVE_DIMS)
            begin
                if (carry)
                begin
                    coord_next[i] = wrap ? '0 : inc[COORD_W-1:0];
                end
                carry = carry & wrap;
            end
            else
            begin
                coord_next[i] = '0;
            end
        end
        if (cmd.clear)
        begin
            coord_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_reg <= '0;
        end
        else
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

`include "tolerance_compare_error_indexer_macros.svh"

    `TCI_ASSERT(a_clear_zeroes, cmd.clear |=> coord_reg == '0, "odometer not cleared after last item")

endmodule

// ===== rtl/core/tci_compare.sv =====
// ----------------------------------------------------------------------------
// tci_compare
// Exact tolerance check |a-b| > abs_tol + rel_tol*|b| in Q32.32, two stages.
// ----------------------------------------------------------------------------
module tci_compare
    import tci_pkg::*;
(
    input  logic                      clk,
    input  logic                      load,
    input  logic signed [VALUE_W-1:0] test_value,
    input  logic signed [VALUE_W-1:0] ref_value,
    input  logic [TOL_W-1:0]          abs_tol,
    input  logic [TOL_W-1:0]          rel_tol,
    output logic                      is_error
);

    localparam int WIDE_W = 2 * TOL_W;

    logic [VALUE_W-1:0]  ref_mag;
    logic [VALUE_W:0]    diff_raw;
    logic [VALUE_W:0]    diff_mag;
    logic [WIDE_W-1:0]   prod;
    logic [WIDE_W-1:0]   prod_reg;
    logic [VALUE_W:0]    diff_reg;
    logic [WIDE_W-1:0]   bound;
    logic [WIDE_W-1:0]   diff_wide;

    // first stage: magnitudes and the relative term
    always_comb
    begin
        ref_mag  = ref_value[VALUE_W-1] ? ({VALUE_W{1'b0}} - ref_value) : ref_value;
        diff_raw = {test_value[VALUE_W-1], test_value} - {ref_value[VALUE_W-1], ref_value};
        diff_mag = diff_raw[VALUE_W] ? ({(VALUE_W+1){1'b0}} - diff_raw) : diff_raw;
        prod     = {{(WIDE_W-TOL_W){1'b0}}, rel_tol} * {{(WIDE_W-VALUE_W){1'b0}}, ref_mag};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod;
            diff_reg <= diff_mag;
        end
    end

    // second stage: bound and compare, both in Q32.32
    always_comb
    begin
        bound     = {16'd0, abs_tol, 16'd0} + prod_reg;
        diff_wide = {{(WIDE_W-VALUE_W-17){1'b0}}, diff_reg, 16'd0};
        is_error  = (diff_wide > bound);
    end

endmodule

// ===== rtl/core/tolerance_compare_error_indexer.sv =====
// ----------------------------------------------------------------------------
// tolerance_compare_error_indexer
// Flags element pairs outside an absolute/relative tolerance, tags each with
// its array coordinate and keeps a running, saturating mismatch count.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+-------------
//  in_ch    | in  | test_value, ref_value, last              | valid/ready
//  out_ch   | out | is_error, coord_0..3, echo_test/ref,     | valid/ready
//           |     | error_total, end_of_array                |
//  cfg      | in  | cfg_index, cfg_data                      | cfg_we only
//
//  One item per cycle sustained while out_ch is ready; a result appears once its item
//  has passed the input register, multiplier register and result register.
//  The 32x32 multiply and the 64-bit bound compare each take one stage.
//  in_ch.ready is low only when all three registers are full and out_ch stalls.
//  Reset clears coordinates, mismatch count and tolerances; extents reset to 1.
// ----------------------------------------------------------------------------
module tolerance_compare_error_indexer
    import tci_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    tci_stream_if.sink             in_ch,
    tci_stream_if.source           out_ch
);

    // configuration
    logic [TOL_W-1:0] abs_tol_reg;
    logic [TOL_W-1:0] rel_tol_reg;
    coord_vec_t       extent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_tol_reg <= '0;
            rel_tol_reg <= '0;
            for (int i = 0; i < NUM_EXTENTS; i++)
            begin
                extent_reg[i] <= {{(COORD_W-1){1'b0}}, 1'b1};
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ABS_TOL:  abs_tol_reg   <= cfg_data[TOL_W-1:0];
                REG_REL_TOL:  rel_tol_reg   <= cfg_data[TOL_W-1:0];
                REG_EXTENT_0: extent_reg[0] <= cfg_data[COORD_W-1:0];
                REG_EXTENT_1: extent_reg[1] <= cfg_data[COORD_W-1:0];
                REG_EXTENT_2: extent_reg[2] <= cfg_data[COORD_W-1:0];
                REG_EXTENT_3: extent_reg[3] <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    logic in_valid_reg,  in_valid_next;
    logic mid_valid_reg, mid_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, mid_free, in_free;
    logic in_accept, mid_load, out_load;

    always_comb
    begin
        out_free  = !out_valid_reg || out_ch.ready;
        out_load  = mid_valid_reg && out_free;
        mid_free  = !mid_valid_reg || out_free;
        mid_load  = in_valid_reg && mid_free;
        in_free   = !in_valid_reg || mid_free;
        in_accept = in_ch.valid && in_free;

        in_valid_next  = in_accept ? 1'b1 : (mid_load ? 1'b0 : in_valid_reg);
        mid_valid_next = mid_load  ? 1'b1 : (out_load ? 1'b0 : mid_valid_reg);
        out_valid_next = out_load  ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);
    end

    assign in_ch.ready = in_free;

    // coordinates are taken at acceptance, then the odometer steps or clears
    odo_cmd_t   odo_cmd;
    coord_vec_t coord_now;

    assign odo_cmd.step  = in_accept && !in_ch.data.last;
    assign odo_cmd.clear = in_accept && in_ch.data.last;

    tci_odometer #(
        .MAX_DIMS (MAX_DIMS)
    ) u_odometer (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (odo_cmd),
        .extent (extent_reg),
        .coord  (coord_now)
    );

    // payload registers
    in_item_t   in_data_reg;
    coord_vec_t in_coord_reg;
    in_item_t   mid_data_reg;
    coord_vec_t mid_coord_reg;
    out_item_t  out_data_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg  <= in_ch.data;
            in_coord_reg <= coord_now;
        end
        if (mid_load)
        begin
            mid_data_reg  <= in_data_reg;
            mid_coord_reg <= in_coord_reg;
        end
    end

    logic cmp_error;

    tci_compare u_compare (
        .clk        (clk),
        .load       (mid_load),
        .test_value (in_data_reg.test_value),
        .ref_value  (in_data_reg.ref_value),
        .abs_tol    (abs_tol_reg),
        .rel_tol    (rel_tol_reg),
        .is_error   (cmp_error)
    );

    // mismatch count, updated in item order at the result register
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] total;

    always_comb
    begin
        total      = (cmp_error && (count_reg != '1)) ? (count_reg + 1'b1) : count_reg;
        count_next = count_reg;
        if (out_load)
        begin
            count_next = mid_data_reg.last ? '0 : total;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.is_error     <= cmp_error;
            out_data_reg.coord_0      <= mid_coord_reg[0];
            out_data_reg.coord_1      <= mid_coord_reg[1];
            out_data_reg.coord_2      <= mid_coord_reg[2];
            out_data_reg.coord_3      <= mid_coord_reg[3];
            out_data_reg.echo_test    <= mid_data_reg.test_value;
            out_data_reg.echo_ref     <= mid_data_reg.ref_value;
            out_data_reg.error_total  <= total;
            out_data_reg.end_of_array <= mid_data_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

`include "tolerance_compare_error_indexer_macros.svh"

    `TCI_ASSERT(a_in_kept, in_valid_reg && !mid_load |=> in_valid_reg, "input stage item lost")
    `TCI_ASSERT(a_mid_kept, mid_valid_reg && !out_load |=> mid_valid_reg && $stable(mid_data_reg), "middle stage item lost or changed")
    `TCI_ASSERT(a_count_cleared, out_load && mid_data_reg.last |=> count_reg == '0, "count not cleared after last item")
    `TCI_ASSERT_NEVER(a_error_uncounted, out_ch.valid && out_ch.data.is_error && (out_ch.data.error_total == '0), "mismatch shown with zero total")

endmodule

// ===== tb/tolerance_compare_error_indexer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tolerance_compare_error_indexer_tb
// Drives element pairs through the tolerance compare and checks every result
// against a cycle-free predictor: mismatch flag, odometer coordinate, echoed
// values, running count and end marker. A directed table comes first, then
// random arrays over a series of register settings and handshake pressures.
// ----------------------------------------------------------------------------
module tolerance_compare_error_indexer_tb;
    import tci_pkg::*;

    localparam int DUT_MAX_DIMS    = DEF_MAX_DIMS;
    localparam int LIVE_DIMS       = (DUT_MAX_DIMS < NUM_EXTENTS) ? DUT_MAX_DIMS : NUM_EXTENTS;
    localparam int LATENCY         = 3;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int MAX_SPAN        = 48;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam longint VALUE_MIN = -(64'sd1 <<< 31);
    localparam longint VALUE_MAX = (64'sd1 <<< 31) - 1;

    typedef enum logic {ROW_WRITE, ROW_PAIR} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        in_item_t               pair;
        logic                   typed;
        logic                   exp_error;
        logic [COUNT_W-1:0]     exp_total;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tci_stream_if #(.data_t(in_item_t))  in_ch ();
    tci_stream_if #(.data_t(out_item_t)) out_ch ();

    tolerance_compare_error_indexer #(
        .MAX_DIMS(DUT_MAX_DIMS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // Shadow of the block's registers and state
    logic [TOL_W-1:0]   abs_tol_q;
    logic [TOL_W-1:0]   rel_tol_q;
    logic [COORD_W-1:0] extent_q [NUM_EXTENTS];
    logic [COORD_W-1:0] coord_q [NUM_EXTENTS];
    logic [COUNT_W-1:0] mismatch_q;

    out_item_t   pending_results [$];
    plan_row_t   directed_plan [$];
    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 73;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge clk)
        out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_result(out_ch.data);
    end

    // Tolerance bound in Q32.32: abs_tol widened plus the exact rel_tol*|ref|
    function automatic logic [63:0] tol_limit(input logic [VALUE_W-1:0] refv);
        longint     r;
        logic [63:0] mag;
        r   = longint'($signed(refv));
        mag = (r < 0) ? 64'(-r) : 64'(r);
        return ({32'b0, abs_tol_q} << 16) + {32'b0, rel_tol_q} * mag;
    endfunction

    function automatic out_item_t predict_result(input in_item_t pair);
        longint             a;
        longint             b;
        longint             d;
        logic [63:0]        dev;
        logic               mismatch;
        logic               carry;
        logic [COORD_W:0]   bumped;
        logic [COORD_W-1:0] shown [NUM_EXTENTS];
        out_item_t          res;
        a   = longint'($signed(pair.test_value));
        b   = longint'($signed(pair.ref_value));
        d   = a - b;
        if (d < 0)
            d = -d;
        dev      = 64'(d) << 16;
        mismatch = dev > tol_limit(pair.ref_value);
        if (mismatch && mismatch_q != '1)
            mismatch_q++;
        for (int i = 0; i < NUM_EXTENTS; i++)
            shown[i] = (i < LIVE_DIMS) ? coord_q[i] : '0;
        res.is_error     = mismatch;
        res.coord_0      = shown[0];
        res.coord_1      = shown[1];
        res.coord_2      = shown[2];
        res.coord_3      = shown[3];
        res.echo_test    = pair.test_value;
        res.echo_ref     = pair.ref_value;
        res.error_total  = mismatch_q;
        res.end_of_array = pair.last;
        if (pair.last)
        begin
            foreach (coord_q[i])
                coord_q[i] = '0;
            mismatch_q = '0;
        end
        else
        begin
            // Odometer: a coordinate at or past its extent wraps and carries
            carry = 1'b1;
            for (int i = 0; i < LIVE_DIMS; i++)
            begin
                if (carry)
                begin
                    bumped = {1'b0, coord_q[i]} + 1'b1;
                    if (bumped < {1'b0, extent_q[i]})
                    begin
                        coord_q[i] = bumped[COORD_W-1:0];
                        carry      = 1'b0;
                    end
                    else
                        coord_q[i] = '0;
                end
            end
        end
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: result with nothing expected, expected none got %h", $time, got);
            fail_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            compare_field("is_error", 32'(want.is_error), 32'(got.is_error));
            compare_field("coord_0", 32'(want.coord_0), 32'(got.coord_0));
            compare_field("coord_1", 32'(want.coord_1), 32'(got.coord_1));
            compare_field("coord_2", 32'(want.coord_2), 32'(got.coord_2));
            compare_field("coord_3", 32'(want.coord_3), 32'(got.coord_3));
            compare_field("echo_test", want.echo_test, got.echo_test);
            compare_field("echo_ref", want.echo_ref, got.echo_ref);
            compare_field("error_total", want.error_total, got.error_total);
            compare_field("end_of_array", 32'(want.end_of_array), 32'(got.end_of_array));
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_ABS_TOL:  abs_tol_q   = value;
            REG_REL_TOL:  rel_tol_q   = value;
            REG_EXTENT_0: extent_q[0] = value[COORD_W-1:0];
            REG_EXTENT_1: extent_q[1] = value[COORD_W-1:0];
            REG_EXTENT_2: extent_q[2] = value[COORD_W-1:0];
            REG_EXTENT_3: extent_q[3] = value[COORD_W-1:0];
            default:      ;
        endcase
    endtask

    // Hold valid until the item is taken; predict at the accepting edge
    task automatic push_pair(input in_item_t pair, input logic typed,
                             input logic exp_error, input logic [COUNT_W-1:0] exp_total);
        out_item_t want;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = pair;
        do
            @(posedge clk);
        while (!in_ch.ready);
        want = predict_result(pair);
        if (typed)
        begin
            want.is_error    = exp_error;
            want.error_total = exp_total;
        end
        pending_results.push_back(want);
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 1) @(posedge clk);
    endtask

    function automatic plan_row_t write_row(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] value);
        plan_row_t r;
        r           = '0;
        r.kind      = ROW_WRITE;
        r.reg_index = idx;
        r.reg_value = value;
        return r;
    endfunction

    function automatic plan_row_t pair_row(input logic [31:0] t, input logic [31:0] rv,
                                           input logic l, input logic typed,
                                           input logic err, input logic [31:0] total);
        plan_row_t r;
        r                 = '0;
        r.kind            = ROW_PAIR;
        r.pair.test_value = t;
        r.pair.ref_value  = rv;
        r.pair.last       = l;
        r.typed           = typed;
        r.exp_error       = err;
        r.exp_total       = total;
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_tol();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            5:       return $urandom;
            default: return $urandom >> $urandom_range(8, 30);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_extent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd65535;
            2:       return $urandom;
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    function automatic in_item_t random_pair();
        in_item_t    p;
        logic [63:0] gap;
        longint      r;
        longint      t;
        int unsigned style;
        p.ref_value  = $urandom;
        p.test_value = $urandom;
        p.last       = 1'b0;
        style        = $urandom_range(0, 9);
        if (style == 3)
            p.test_value = p.ref_value;
        else if (style >= 4 && style <= 6)
        begin
            gap          = 64'($urandom >> $urandom_range(0, 31));
            p.test_value = $urandom_range(0, 1) ? p.ref_value + gap[31:0]
                                                : p.ref_value - gap[31:0];
        end
        else if (style >= 7)
        begin
            // Land on the bound or one step past it
            p.ref_value = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1))
                p.ref_value = -p.ref_value;
            gap = (tol_limit(p.ref_value) >> 16) + 64'($urandom_range(0, 1));
            r   = longint'($signed(p.ref_value));
            t   = $urandom_range(0, 1) ? r + longint'(gap) : r - longint'(gap);
            if (gap < 64'h1_0000_0000 && t >= VALUE_MIN && t <= VALUE_MAX)
                p.test_value = 32'(t);
            else
                p.test_value = p.ref_value;
        end
        return p;
    endfunction

    initial
    begin
        int unsigned left;
        longint      span;
        in_item_t    pair;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_ABS_TOL;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        abs_tol_q    = '0;
        rel_tol_q    = '0;
        mismatch_q   = '0;
        foreach (extent_q[i])
        begin
            extent_q[i] = 16'd1;
            coord_q[i]  = '0;
        end
        left = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: zero tolerance, all extents one
        directed_plan.push_back(pair_row(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'd0));
        directed_plan.push_back(pair_row(32'h0000_0001, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'd1));
        directed_plan.push_back(pair_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 1'b1, 32'd2));
        directed_plan.push_back(pair_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 32'd3));
        directed_plan.push_back(pair_row(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 1'b0, 32'd3));
        // 1.0 + 0.5*|ref|; 2x2x(zero)x2 array; upper data bits and spare indexes dropped
        directed_plan.push_back(write_row(REG_ABS_TOL, 32'h0001_0000));
        directed_plan.push_back(write_row(REG_REL_TOL, 32'h0000_8000));
        directed_plan.push_back(write_row(REG_EXTENT_0, 32'hABCD_0002));
        directed_plan.push_back(write_row(REG_EXTENT_1, 32'd2));
        directed_plan.push_back(write_row(REG_EXTENT_2, 32'd0));
        directed_plan.push_back(write_row(REG_EXTENT_3, 32'd2));
        directed_plan.push_back(write_row(REG_SPARE_6, 32'hFFFF_FFFF));
        directed_plan.push_back(write_row(REG_SPARE_7, 32'h1234_5678));
        directed_plan.push_back(pair_row(32'h0004_0000, 32'h0002_0000, 1'b0, 1'b0, 1'b0, 32'd0));
        directed_plan.push_back(pair_row(32'h0004_0001, 32'h0002_0000, 1'b0, 1'b0, 1'b0, 32'd0));
        directed_plan.push_back(pair_row(32'h0000_0000, 32'hFFFE_0000, 1'b0, 1'b0, 1'b0, 32'd0));
        directed_plan.push_back(pair_row(32'hFFFB_FFFF, 32'hFFFE_0000, 1'b0, 1'b0, 1'b0, 32'd0));
        directed_plan.push_back(pair_row(32'h0001_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0));
        directed_plan.push_back(pair_row(32'h0001_0001, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0));
        directed_plan.push_back(pair_row(32'hFFFF_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0));
        directed_plan.push_back(pair_row(32'hFFFE_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'd0));
        // Past the full array without an end marker: odometer wraps
        directed_plan.push_back(pair_row(32'h1234_5678, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 32'd0));
        directed_plan.push_back(pair_row(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'd0));
        // Shrink the fastest extent under a live coordinate
        directed_plan.push_back(pair_row(32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0));
        directed_plan.push_back(write_row(REG_EXTENT_0, 32'd1));
        directed_plan.push_back(pair_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0));
        directed_plan.push_back(pair_row(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'd0));
        // Widest tolerances: nothing can fail
        directed_plan.push_back(write_row(REG_ABS_TOL, 32'hFFFF_FFFF));
        directed_plan.push_back(write_row(REG_REL_TOL, 32'hFFFF_FFFF));
        directed_plan.push_back(write_row(REG_EXTENT_0, 32'h0000_FFFF));
        directed_plan.push_back(pair_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 1'b0, 32'd0));
        directed_plan.push_back(pair_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 32'd0));
        directed_plan.push_back(pair_row(32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 32'd0));

        foreach (directed_plan[n])
        begin
            if (directed_plan[n].kind == ROW_WRITE)
            begin
                drain();
                write_reg(directed_plan[n].reg_index, directed_plan[n].reg_value);
            end
            else
                push_pair(directed_plan[n].pair, directed_plan[n].typed,
                          directed_plan[n].exp_error, directed_plan[n].exp_total);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph * 3 / PHASES)
                0:
                begin
                    send_idle_pct = 35;
                    recv_idle_pct = 73;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 35;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            drain();
            // Leave some registers alone so arrays run on across settings
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_ABS_TOL, pick_tol());
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_REL_TOL, pick_tol());
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_EXTENT_0, pick_extent());
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_EXTENT_1, pick_extent());
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_EXTENT_2, pick_extent());
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_EXTENT_3, pick_extent());
            if ($urandom_range(0, 4) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (left == 0)
                begin
                    span = 1;
                    for (int i = 0; i < LIVE_DIMS; i++)
                    begin
                        if (extent_q[i] != 0)
                            span = span * longint'(extent_q[i]);
                        if (span > MAX_SPAN)
                            span = MAX_SPAN + 1;
                    end
                    // Mostly whole arrays; some cut short or run over
                    if ($urandom_range(0, 3) == 0 || span > MAX_SPAN)
                        left = $urandom_range(1, 16);
                    else
                        left = int'(span);
                end
                pair      = random_pair();
                left--;
                pair.last = (left == 0);
                push_pair(pair, 1'b0, 1'b0, '0);
            end
        end

        drain();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
